// ===== rtl/lsrr_pkg.sv =====
// Shared constants, beat types and queue index helpers for the lane shim router.
package lsrr_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int DATA_WIDTH  = 32;
    localparam int LANES       = 4;
    localparam int PORTS       = LANES + 1;
    localparam int LANE_W      = 2;
    localparam int PORT_W      = $clog2(PORTS);
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CRED_W      = 8;
    localparam int STALL_W     = 2;

    localparam logic [CRED_W-1:0] CRED_RESET = 8'd8;

    // Port numbering shared by arrival, credit and overflow masks.
    localparam int UP_PORT    = 0;
    localparam int LANE_PORT0 = 1;

    // Depth of the beat queues between front, back and result side.
    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef logic [PORTS-1:0] port_mask_t;

    typedef struct packed {
        port_mask_t                          arrive;
        logic [LANE_W-1:0]                   up_lane;
        logic [DATA_WIDTH-1:0]               up_data;
        logic [LANES-1:0][DATA_WIDTH-1:0]    lane_data;
        port_mask_t                          credit_ret;
    } tick_t;

    typedef struct packed {
        logic                  down_valid;
        logic [LANE_W-1:0]     down_lane;
        logic [DATA_WIDTH-1:0] down_data;
        logic                  merge_valid;
        logic [LANE_W-1:0]     merge_lane;
        logic [DATA_WIDTH-1:0] merge_data;
        port_mask_t            credit_out;
        logic [STALL_W-1:0]    stall_count;
        logic                  contention;
        port_mask_t            overflow;
    } result_t;

    // Slot of the next free entry of a ring queue.
    function automatic logic [QIDX_W-1:0] tail_slot(input logic [QIDX_W-1:0] head,
                                                    input logic [QCNT_W-1:0] cnt);
        logic [QCNT_W:0] sum;
        sum = (QCNT_W + 1)'(head) + (QCNT_W + 1)'(cnt);
        if (sum >= (QCNT_W + 1)'(QUEUE_DEPTH))
        begin
            sum = sum - (QCNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[QIDX_W-1:0];
    endfunction

    function automatic logic [QIDX_W-1:0] head_step(input logic [QIDX_W-1:0] head);
        return (head == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    endfunction

endpackage

// ===== rtl/lane_shim_rr_credit_router_unit.sv =====
// Top level of the lane shim router: front queue, tick engine and result queue.
//
// Channel   Handshake            Beat
// input     push / full          one network tick: arrivals and credit returns
// result    empty / pop          one tick outcome: forwards, credits, stalls, drops
// config    cfg_we / cfg_wdata   credit limit, reloads all five credit counters
//
// One tick beat is taken every cycle unless the result queue is full; the tick engine computes
// its result in that same cycle. A beat is registered in the front queue and its result in the
// result queue, from which the result shows on the result ports and can be popped.
// After reset all queues are empty, all credits and the limit are 8, arbitration starts at lane 0.
// Stalls on the result side back up through the two-entry queues to full.
module lane_shim_rr_credit_router_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             up_valid,
    input  logic [1:0]                       up_lane,
    input  logic [31:0]                      up_data,
    input  logic [3:0]                       lane_valid_mask,
    input  logic [31:0]                      lane0_data,
    input  logic [31:0]                      lane1_data,
    input  logic [31:0]                      lane2_data,
    input  logic [31:0]                      lane3_data,
    input  logic [4:0]                       credit_return_mask,
    output logic                             empty,
    input  logic                             pop,
    output logic                             down_valid,
    output logic [1:0]                       down_lane,
    output logic [31:0]                      down_data,
    output logic                             merge_valid,
    output logic [1:0]                       merge_lane,
    output logic [31:0]                      merge_data,
    output logic [4:0]                       credit_out_mask,
    output logic [1:0]                       stall_count,
    output logic                             contention,
    output logic [4:0]                       overflow_mask,
    input  logic                             cfg_we,
    input  logic [7:0]                       cfg_wdata
);
    import lsrr_pkg::*;

    logic                             tick_valid, tick_take;
    tick_t                            tick;
    logic                             res_full, res_push;
    result_t                          res_in, res_out;
    logic [LANES-1:0][DATA_WIDTH-1:0] lane_data;

    assign lane_data = {lane3_data, lane2_data, lane1_data, lane0_data};

    lsrr_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .up_valid           (up_valid),
        .up_lane            (up_lane),
        .up_data            (up_data),
        .lane_valid_mask    (lane_valid_mask),
        .lane_data          (lane_data),
        .credit_return_mask (credit_return_mask),
        .tick_valid         (tick_valid),
        .tick_take          (tick_take),
        .tick               (tick)
    );

    lsrr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .tick_valid (tick_valid),
        .tick_take  (tick_take),
        .tick       (tick),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    lsrr_res_fifo u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_in),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    assign down_valid      = res_out.down_valid;
    assign down_lane       = res_out.down_lane;
    assign down_data       = res_out.down_data;
    assign merge_valid     = res_out.merge_valid;
    assign merge_lane      = res_out.merge_lane;
    assign merge_data      = res_out.merge_data;
    assign credit_out_mask = res_out.credit_out;
    assign stall_count     = res_out.stall_count;
    assign contention      = res_out.contention;
    assign overflow_mask   = res_out.overflow;

endmodule

// ===== rtl/lsrr_front.sv =====
// Front end: takes tick beats, builds the per-port arrival mask and queues them.
module lsrr_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         up_valid,
    input  logic [1:0]                   up_lane,
    input  logic [lsrr_pkg::DATA_WIDTH-1:0] up_data,
    input  logic [lsrr_pkg::LANES-1:0]   lane_valid_mask,
    input  logic [lsrr_pkg::LANES-1:0][lsrr_pkg::DATA_WIDTH-1:0] lane_data,
    input  logic [lsrr_pkg::PORTS-1:0]   credit_return_mask,
    output logic                         tick_valid,
    input  logic                         tick_take,
    output lsrr_pkg::tick_t              tick
);
    import lsrr_pkg::*;

    tick_t              buf_mem [FIFO_DEPTH];
    tick_t              in_tick;
    logic [FPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push, do_pop;

    always_comb
    begin
        in_tick.arrive     = {lane_valid_mask, up_valid};
        in_tick.up_lane    = LANE_W'(up_lane);
        in_tick.up_data    = up_data;
        in_tick.lane_data  = lane_data;
        in_tick.credit_ret = credit_return_mask;
    end

    assign full       = (cnt_reg == FCNT_W'(FIFO_DEPTH));
    assign tick_valid = (cnt_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = tick_take && tick_valid;
    assign tick       = buf_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + FCNT_W'(do_push) - FCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_mem[wr_ptr_reg] <= in_tick;
        end
    end

endmodule

// ===== rtl/lsrr_back.sv =====
// Back end: port queues, credit counters, round robin merge; one tick per cycle if !res_full.
module lsrr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lsrr_pkg::CRED_W-1:0]   cfg_wdata,
    input  logic                          tick_valid,
    output logic                          tick_take,
    input  lsrr_pkg::tick_t               tick,
    input  logic                          res_full,
    output logic                          res_push,
    output lsrr_pkg::result_t             res
);
    import lsrr_pkg::*;

    logic [LANE_W-1:0]     upq_lane_mem [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] upq_data_mem [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] laneq_mem [LANES][QUEUE_DEPTH];

    logic [QIDX_W-1:0]  head_reg [PORTS];
    logic [QIDX_W-1:0]  head_next [PORTS];
    logic [QCNT_W-1:0]  cnt_reg [PORTS];
    logic [QCNT_W-1:0]  cnt_next [PORTS];
    logic [QCNT_W-1:0]  cnt_arr [PORTS];
    logic [QIDX_W-1:0]  slot [PORTS];
    logic [CRED_W-1:0]  cred_reg [PORTS];
    logic [CRED_W-1:0]  cred_next [PORTS];
    logic [CRED_W-1:0]  cred_ret [PORTS];
    logic [CRED_W-1:0]  limit_reg;
    logic [LANE_W-1:0]  rr_reg, rr_next;

    port_mask_t            acc, ovf, pop_mask;
    logic [LANE_W-1:0]     head_lane;
    logic [DATA_WIDTH-1:0] head_data;
    logic [LANES-1:0][DATA_WIDTH-1:0] lane_head;
    logic [LANES-1:0]      nonempty;
    logic [PORT_W-1:0]     down_port;
    logic                  up_waiting, down_ok, merge_ok, found;
    logic [LANE_W-1:0]     sel, cand;
    int                    cand_i;

    assign tick_take = tick_valid && !res_full;
    assign res_push  = tick_take;

    always_comb
    begin
        // Arrivals are placed before departures, so a full queue drops even if it drains now.
        for (int p = 0; p < PORTS; p++)
        begin
            acc[p]     = tick.arrive[p] && (cnt_reg[p] != QCNT_W'(QUEUE_DEPTH));
            ovf[p]     = tick.arrive[p] && !acc[p];
            cnt_arr[p] = cnt_reg[p] + QCNT_W'(acc[p]);
            slot[p]    = tail_slot(head_reg[p], cnt_reg[p]);
            cred_ret[p] = (tick.credit_ret[p] && (cred_reg[p] < limit_reg))
                          ? cred_reg[p] + 1'b1 : cred_reg[p];
        end

        // An empty queue that just took a flit has it at the head this same tick.
        head_lane = (cnt_reg[UP_PORT] == '0) ? tick.up_lane : upq_lane_mem[head_reg[UP_PORT]];
        head_data = (cnt_reg[UP_PORT] == '0) ? tick.up_data : upq_data_mem[head_reg[UP_PORT]];
        for (int l = 0; l < LANES; l++)
        begin
            lane_head[l] = (cnt_reg[LANE_PORT0 + l] == '0)
                           ? tick.lane_data[l]
                           : laneq_mem[l][head_reg[LANE_PORT0 + l]];
            nonempty[l]  = (cnt_arr[LANE_PORT0 + l] != '0);
        end

        up_waiting = (cnt_arr[UP_PORT] != '0);
        down_port  = PORT_W'(head_lane) + PORT_W'(LANE_PORT0);
        down_ok    = up_waiting && (cred_ret[down_port] != '0);

        sel   = '0;
        found = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            cand_i = int'(rr_reg) + i;
            if (cand_i >= LANES)
            begin
                cand_i = cand_i - LANES;
            end
            cand = LANE_W'(cand_i);
            if (!found && nonempty[cand])
            begin
                sel   = cand;
                found = 1'b1;
            end
        end
        merge_ok = found && (cred_ret[UP_PORT] != '0);

        pop_mask          = '0;
        pop_mask[UP_PORT] = down_ok;
        for (int l = 0; l < LANES; l++)
        begin
            pop_mask[LANE_PORT0 + l] = merge_ok && (sel == LANE_W'(l));
        end

        for (int p = 0; p < PORTS; p++)
        begin
            cred_next[p] = cred_ret[p];
            cnt_next[p]  = cnt_arr[p] - QCNT_W'(pop_mask[p]);
            head_next[p] = pop_mask[p] ? head_step(head_reg[p]) : head_reg[p];
        end
        if (down_ok)
        begin
            cred_next[down_port] = cred_ret[down_port] - 1'b1;
        end
        if (merge_ok)
        begin
            cred_next[UP_PORT] = cred_ret[UP_PORT] - 1'b1;
        end
        rr_next = merge_ok ? ((sel == LANE_W'(LANES - 1)) ? '0 : sel + 1'b1) : rr_reg;

        res.down_valid  = down_ok;
        res.down_lane   = down_ok ? head_lane : '0;
        res.down_data   = down_ok ? head_data : '0;
        res.merge_valid = merge_ok;
        res.merge_lane  = merge_ok ? sel : '0;
        res.merge_data  = merge_ok ? lane_head[sel] : '0;
        res.credit_out  = pop_mask;
        res.stall_count = STALL_W'(up_waiting && !down_ok) + STALL_W'(found && !merge_ok);
        res.contention  = ($countones(nonempty) > 1);
        res.overflow    = ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= CRED_RESET;
            rr_reg    <= '0;
            for (int p = 0; p < PORTS; p++)
            begin
                head_reg[p] <= '0;
                cnt_reg[p]  <= '0;
                cred_reg[p] <= CRED_RESET;
            end
        end
        else if (cfg_we)
        begin
            // A new limit reloads every credit counter.
            limit_reg <= cfg_wdata;
            for (int p = 0; p < PORTS; p++)
            begin
                cred_reg[p] <= cfg_wdata;
            end
        end
        else if (tick_take)
        begin
            rr_reg <= rr_next;
            for (int p = 0; p < PORTS; p++)
            begin
                head_reg[p] <= head_next[p];
                cnt_reg[p]  <= cnt_next[p];
                cred_reg[p] <= cred_next[p];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_take && acc[UP_PORT])
        begin
            upq_lane_mem[slot[UP_PORT]] <= tick.up_lane;
            upq_data_mem[slot[UP_PORT]] <= tick.up_data;
        end
        for (int l = 0; l < LANES; l++)
        begin
            if (tick_take && acc[LANE_PORT0 + l])
            begin
                laneq_mem[l][slot[LANE_PORT0 + l]] <= tick.lane_data[l];
            end
        end
    end

endmodule

// ===== rtl/lsrr_res_fifo.sv =====
// Result queue that holds finished beats until the consumer pops them.
module lsrr_res_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_push,
    input  lsrr_pkg::result_t  res_in,
    output logic               res_full,
    output logic               empty,
    input  logic               pop,
    output lsrr_pkg::result_t  res_out
);
    import lsrr_pkg::*;

    result_t            buf_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign res_full = (cnt_reg == FCNT_W'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;
    assign res_out  = buf_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + FCNT_W'(do_push) - FCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_mem[wr_ptr_reg] <= res_in;
        end
    end

endmodule

// ===== tb/lane_shim_rr_credit_router_unit_tb.sv =====
// Self-checking testbench for the lane shim router: directed ticks, then random ticks per credit limit.
`timescale 1ns / 1ps

module lane_shim_rr_credit_router_unit_tb;

    import lsrr_pkg::*;

    localparam int STUCK_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int RANDOM_PHASES   = 6;

    typedef struct packed {
        logic                             up_valid;
        logic [1:0]                       up_lane;
        logic [DATA_WIDTH-1:0]            up_data;
        logic [LANES-1:0]                 lane_mask;
        logic [LANES-1:0][DATA_WIDTH-1:0] lane_data;
        logic [PORTS-1:0]                 credit_ret;
    } tick_stim_t;

    typedef enum logic {ROW_TICK, ROW_LIMIT} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        tick_stim_t stim;
        int         reps;
        bit         typed;
        result_t    want;
        logic [7:0] limit;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic up_valid = 1'b0;
    logic [1:0] up_lane = '0;
    logic [31:0] up_data = '0;
    logic [3:0] lane_valid_mask = '0;
    logic [31:0] lane0_data = '0;
    logic [31:0] lane1_data = '0;
    logic [31:0] lane2_data = '0;
    logic [31:0] lane3_data = '0;
    logic [4:0] credit_return_mask = '0;
    logic empty;
    logic pop = 1'b0;
    logic down_valid;
    logic [1:0] down_lane;
    logic [31:0] down_data;
    logic merge_valid;
    logic [1:0] merge_lane;
    logic [31:0] merge_data;
    logic [4:0] credit_out_mask;
    logic [1:0] stall_count;
    logic contention;
    logic [4:0] overflow_mask;
    logic cfg_we = 1'b0;
    logic [7:0] cfg_wdata = '0;

    // Predictor state: per-port ring queues, credit counters and arbitration pointer.
    logic [1:0]            up_lane_store [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] up_data_store [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] lane_store [LANES][QUEUE_DEPTH];
    int unsigned           q_head [PORTS];
    int unsigned           q_fill [PORTS];
    int unsigned           free_cred [PORTS];
    logic [7:0]            credit_limit;
    int unsigned           rr_next;

    result_t   pending_outcomes [$];
    plan_row_t directed_plan [$];
    int        mismatches = 0;
    int        stuck_cycles = 0;
    bit        idle_on = 1'b1;

    lane_shim_rr_credit_router_unit i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .up_valid           (up_valid),
        .up_lane            (up_lane),
        .up_data            (up_data),
        .lane_valid_mask    (lane_valid_mask),
        .lane0_data         (lane0_data),
        .lane1_data         (lane1_data),
        .lane2_data         (lane2_data),
        .lane3_data         (lane3_data),
        .credit_return_mask (credit_return_mask),
        .empty              (empty),
        .pop                (pop),
        .down_valid         (down_valid),
        .down_lane          (down_lane),
        .down_data          (down_data),
        .merge_valid        (merge_valid),
        .merge_lane         (merge_lane),
        .merge_data         (merge_data),
        .credit_out_mask    (credit_out_mask),
        .stall_count        (stall_count),
        .contention         (contention),
        .overflow_mask      (overflow_mask),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata)
    );

    always #5 clk = ~clk;

    // One network tick: arrivals first, then credit returns, then both forwarding directions.
    function automatic result_t route_tick(input tick_stim_t t);
        result_t           r;
        int                i;
        int unsigned       out_port, busy, stalls;
        logic [QIDX_W-1:0] slot, hd;
        logic [LANE_W-1:0] sel, cand;
        bit                found;
        r = '0;
        stalls = 0;
        busy = 0;
        sel = '0;
        found = 1'b0;
        if (t.up_valid)
        begin
            if (q_fill[UP_PORT] >= QUEUE_DEPTH)
            begin
                r.overflow[UP_PORT] = 1'b1;
            end
            else
            begin
                slot = QIDX_W'((q_head[UP_PORT] + q_fill[UP_PORT]) % QUEUE_DEPTH);
                up_lane_store[slot] = t.up_lane;
                up_data_store[slot] = t.up_data;
                q_fill[UP_PORT]++;
            end
        end
        for (i = 0; i < LANES; i++)
        begin
            if (t.lane_mask[i])
            begin
                if (q_fill[LANE_PORT0 + i] >= QUEUE_DEPTH)
                begin
                    r.overflow[LANE_PORT0 + i] = 1'b1;
                end
                else
                begin
                    slot = QIDX_W'((q_head[LANE_PORT0 + i] + q_fill[LANE_PORT0 + i])
                                   % QUEUE_DEPTH);
                    lane_store[i][slot] = t.lane_data[i];
                    q_fill[LANE_PORT0 + i]++;
                end
            end
        end
        for (i = 0; i < PORTS; i++)
        begin
            if (t.credit_ret[i] && free_cred[i] < 32'(credit_limit))
            begin
                free_cred[i]++;
            end
        end
        if (q_fill[UP_PORT] != 0)
        begin
            hd = QIDX_W'(q_head[UP_PORT]);
            out_port = LANE_PORT0 + int'(up_lane_store[hd]);
            if (free_cred[out_port] > 0)
            begin
                free_cred[out_port]--;
                r.down_valid = 1'b1;
                r.down_lane = up_lane_store[hd];
                r.down_data = up_data_store[hd];
                r.credit_out[UP_PORT] = 1'b1;
                q_head[UP_PORT] = (q_head[UP_PORT] + 1) % QUEUE_DEPTH;
                q_fill[UP_PORT]--;
            end
            else
            begin
                stalls++;
            end
        end
        for (i = 0; i < LANES; i++)
        begin
            if (q_fill[LANE_PORT0 + i] != 0)
            begin
                busy++;
            end
        end
        if (busy != 0)
        begin
            for (i = 0; i < LANES; i++)
            begin
                cand = LANE_W'((rr_next + i) % LANES);
                if (!found && q_fill[LANE_PORT0 + int'(cand)] != 0)
                begin
                    sel = cand;
                    found = 1'b1;
                end
            end
            if (free_cred[UP_PORT] > 0)
            begin
                free_cred[UP_PORT]--;
                hd = QIDX_W'(q_head[LANE_PORT0 + int'(sel)]);
                r.merge_valid = 1'b1;
                r.merge_lane = sel;
                r.merge_data = lane_store[sel][hd];
                r.credit_out[LANE_PORT0 + int'(sel)] = 1'b1;
                q_head[LANE_PORT0 + int'(sel)] = (q_head[LANE_PORT0 + int'(sel)] + 1)
                                                 % QUEUE_DEPTH;
                q_fill[LANE_PORT0 + int'(sel)]--;
                rr_next = (int'(sel) + 1) % LANES;
            end
            else
            begin
                stalls++;
            end
        end
        r.stall_count = STALL_W'(stalls);
        r.contention = (busy > 1);
        return r;
    endfunction

    function automatic tick_stim_t mk_tick(input logic uv, input logic [1:0] ul,
                                           input logic [31:0] ud, input logic [3:0] lmask,
                                           input logic [31:0] l0, input logic [31:0] l1,
                                           input logic [31:0] l2, input logic [31:0] l3,
                                           input logic [4:0] ret);
        tick_stim_t t;
        t.up_valid = uv;
        t.up_lane = ul;
        t.up_data = ud;
        t.lane_mask = lmask;
        t.lane_data[0] = l0;
        t.lane_data[1] = l1;
        t.lane_data[2] = l2;
        t.lane_data[3] = l3;
        t.credit_ret = ret;
        return t;
    endfunction

    function automatic result_t mk_out(input logic dv, input logic [1:0] dl,
                                       input logic [31:0] dd, input logic mv,
                                       input logic [1:0] ml, input logic [31:0] md,
                                       input logic [4:0] co, input logic [1:0] st,
                                       input logic ct, input logic [4:0] ov);
        result_t r;
        r.down_valid = dv;
        r.down_lane = dl;
        r.down_data = dd;
        r.merge_valid = mv;
        r.merge_lane = ml;
        r.merge_data = md;
        r.credit_out = co;
        r.stall_count = st;
        r.contention = ct;
        r.overflow = ov;
        return r;
    endfunction

    function automatic void add_tick(input tick_stim_t t, input int reps, input bit typed,
                                     input result_t want);
        plan_row_t row;
        row.kind = ROW_TICK;
        row.stim = t;
        row.reps = reps;
        row.typed = typed;
        row.want = want;
        row.limit = '0;
        directed_plan.insert(directed_plan.size(), row);
    endfunction

    function automatic void add_limit(input logic [7:0] v);
        plan_row_t row;
        row.kind = ROW_LIMIT;
        row.stim = '0;
        row.reps = 0;
        row.typed = 1'b0;
        row.want = '0;
        row.limit = v;
        directed_plan.insert(directed_plan.size(), row);
    endfunction

    // Presents one tick beat and waits for it to be taken; push stays high afterwards.
    task automatic send_tick(input tick_stim_t t, input bit use_typed, input result_t typed_want);
        result_t predicted;
        while (idle_on && $urandom_range(99) < 16)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        up_valid <= t.up_valid;
        up_lane <= t.up_lane;
        up_data <= t.up_data;
        lane_valid_mask <= t.lane_mask;
        lane0_data <= t.lane_data[0];
        lane1_data <= t.lane_data[1];
        lane2_data <= t.lane_data[2];
        lane3_data <= t.lane_data[3];
        credit_return_mask <= t.credit_ret;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        predicted = route_tick(t);
        pending_outcomes.insert(pending_outcomes.size(), use_typed ? typed_want : predicted);
    endtask

    // The limit is only changed once every outstanding result has been popped.
    task automatic load_credit_limit(input logic [7:0] v);
        int i;
        push <= 1'b0;
        while (pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        credit_limit = v;
        for (i = 0; i < PORTS; i++)
        begin
            free_cred[i] = 32'(v);
        end
    endtask

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %h, got %h", $time, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat popped with nothing outstanding", $time);
            end
            else
            begin
                want = pending_outcomes[0];
                pending_outcomes.delete(0);
                compare_field("down_valid", 32'(want.down_valid), 32'(down_valid));
                compare_field("down_lane", 32'(want.down_lane), 32'(down_lane));
                compare_field("down_data", want.down_data, down_data);
                compare_field("merge_valid", 32'(want.merge_valid), 32'(merge_valid));
                compare_field("merge_lane", 32'(want.merge_lane), 32'(merge_lane));
                compare_field("merge_data", want.merge_data, merge_data);
                compare_field("credit_out_mask", 32'(want.credit_out), 32'(credit_out_mask));
                compare_field("stall_count", 32'(want.stall_count), 32'(stall_count));
                compare_field("contention", 32'(want.contention), 32'(contention));
                compare_field("overflow_mask", 32'(want.overflow), 32'(overflow_mask));
            end
        end
        pop <= (!idle_on || $urandom_range(99) >= 16);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("lane_shim_rr_credit_router_unit regression: fail");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin : stimulus
        tick_stim_t  t;
        logic [7:0]  phase_limit [RANDOM_PHASES];
        int unsigned up_pct, lane_pct, ret_pct;
        int          i, phase, n;

        for (i = 0; i < PORTS; i++)
        begin
            q_head[i] = 0;
            q_fill[i] = 0;
            free_cred[i] = 32'(CRED_RESET);
        end
        credit_limit = CRED_RESET;
        rr_next = 0;

        // Returns at the limit must saturate, so the first tick shows nothing at all.
        add_tick(mk_tick(1'b0, 2'd0, 32'h0, 4'h0, 32'h0, 32'h0, 32'h0, 32'h0, 5'h1F), 1, 1'b1,
                 mk_out(1'b0, 2'd0, 32'h0, 1'b0, 2'd0, 32'h0, 5'h00, 2'd0, 1'b0, 5'h00));
        add_tick(mk_tick(1'b1, 2'd3, 32'hFFFF_FFFF, 4'h0, 32'h0, 32'h0, 32'h0, 32'h0, 5'h00),
                 1, 1'b1,
                 mk_out(1'b1, 2'd3, 32'hFFFF_FFFF, 1'b0, 2'd0, 32'h0, 5'h01, 2'd0, 1'b0, 5'h00));
        add_tick(mk_tick(1'b1, 2'd0, 32'h0, 4'h0, 32'h0, 32'h0, 32'h0, 32'h0, 5'h00), 1, 1'b1,
                 mk_out(1'b1, 2'd0, 32'h0, 1'b0, 2'd0, 32'h0, 5'h01, 2'd0, 1'b0, 5'h00));
        add_tick(mk_tick(1'b1, 2'd1, 32'h8000_0001, 4'hF, 32'h0, 32'hFFFF_FFFF, 32'hA5A5_A5A5,
                         32'h5A5A_5A5A, 5'h00), 1, 1'b1,
                 mk_out(1'b1, 2'd1, 32'h8000_0001, 1'b1, 2'd0, 32'h0, 5'h03, 2'd0, 1'b1, 5'h00));
        add_tick('0, 1, 1'b1,
                 mk_out(1'b0, 2'd0, 32'h0, 1'b1, 2'd1, 32'hFFFF_FFFF, 5'h04, 2'd0, 1'b1, 5'h00));
        add_tick('0, 1, 1'b1,
                 mk_out(1'b0, 2'd0, 32'h0, 1'b1, 2'd2, 32'hA5A5_A5A5, 5'h08, 2'd0, 1'b1, 5'h00));
        add_tick('0, 1, 1'b1,
                 mk_out(1'b0, 2'd0, 32'h0, 1'b1, 2'd3, 32'h5A5A_5A5A, 5'h10, 2'd0, 1'b0, 5'h00));
        // With no credits every head stalls and the queues fill until arrivals are dropped.
        add_limit(8'd0);
        add_tick(mk_tick(1'b1, 2'd2, 32'h0F0F_0F0F, 4'h1, 32'hC3C3_C3C3, 32'h0, 32'h0, 32'h0,
                         5'h00), 9, 1'b0, '0);
        add_tick(mk_tick(1'b1, 2'd1, 32'h7FFF_FFFE, 4'hF, 32'h1, 32'h2, 32'h4, 32'h8, 5'h1F),
                 1, 1'b0, '0);
        add_limit(8'd255);
        add_tick('0, 8, 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[k])
        begin
            if (directed_plan[k].kind == ROW_LIMIT)
            begin
                load_credit_limit(directed_plan[k].limit);
            end
            else
            begin
                for (n = 0; n < directed_plan[k].reps; n++)
                begin
                    send_tick(directed_plan[k].stim, directed_plan[k].typed,
                              directed_plan[k].want);
                end
            end
        end

        phase_limit = '{8'd1, 8'd255, 8'd2, 8'd8, 8'($urandom_range(1, 255)), 8'd3};
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_on = (phase != 2);
            load_credit_limit(phase_limit[phase]);
            up_pct = $urandom_range(20, 95);
            lane_pct = $urandom_range(5, 60);
            ret_pct = $urandom_range(10, 90);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                t.up_valid = ($urandom_range(99) < up_pct);
                t.up_lane = 2'($urandom_range(3));
                t.up_data = $urandom;
                for (i = 0; i < LANES; i++)
                begin
                    t.lane_mask[i] = ($urandom_range(99) < lane_pct);
                    t.lane_data[i] = $urandom;
                end
                for (i = 0; i < PORTS; i++)
                begin
                    t.credit_ret[i] = ($urandom_range(99) < ret_pct);
                end
                send_tick(t, 1'b0, '0);
            end
        end
        idle_on = 1'b1;

        push <= 1'b0;
        while (pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        // A stray beat would be popped and flagged while waiting here.
        repeat (4) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("lane_shim_rr_credit_router_unit regression: pass");
        end
        else
        begin
            $display("lane_shim_rr_credit_router_unit regression: fail");
        end
        $finish;
    end

endmodule
